// File: sv/assert_macros.svh
// Assertion macros for the RTL files; only the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/cdts_pkg.sv
// Types, codes and calendar tables for the clock date and time setter.
package cdts_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDIT,
    S_WSTART,
    S_WWAIT,
    S_DONE
  } state_t;

  localparam logic [2:0] MODE_LOAD   = 3'd0;
  localparam logic [2:0] MODE_UP     = 3'd1;
  localparam logic [2:0] MODE_DOWN   = 3'd2;
  localparam logic [2:0] MODE_SAVE   = 3'd3;
  localparam logic [2:0] MODE_CANCEL = 3'd4;

  localparam logic [2:0] FIELD_HOURS   = 3'd0;
  localparam logic [2:0] FIELD_MINUTES = 3'd1;
  localparam logic [2:0] FIELD_SECONDS = 3'd2;
  localparam logic [2:0] FIELD_DAY     = 3'd3;
  localparam logic [2:0] FIELD_MONTH   = 3'd4;
  localparam logic [2:0] FIELD_YEAR    = 3'd5;

  localparam logic [11:0] YEAR_MIN = 12'd2000;
  localparam logic [11:0] YEAR_MAX = 12'd2099;
  localparam logic [11:0] YEAR_DEF = 12'd2018;

  typedef struct packed {
    logic [2:0]  weekday;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [5:0]  seconds;
    logic [5:0]  minutes;
    logic [4:0]  hours;
  } ld_t;

  typedef struct packed {
    logic        date_changed;
    logic        time_changed;
    logic [2:0]  weekday;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [5:0]  seconds;
    logic [5:0]  minutes;
    logic [4:0]  hours;
  } res_t;

  typedef struct packed {
    logic       done;
    logic [2:0] wday;
  } wd_stat_t;

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      4'd2:                      n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
      default:                   n = 5'd31;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] month_off(input logic [3:0] m);
    logic [2:0] t;
    case (m)
      4'd1:    t = 3'd6;
      4'd2:    t = 3'd2;
      4'd3:    t = 3'd2;
      4'd4:    t = 3'd5;
      4'd5:    t = 3'd0;
      4'd6:    t = 3'd3;
      4'd7:    t = 3'd5;
      4'd8:    t = 3'd1;
      4'd9:    t = 3'd4;
      4'd10:   t = 3'd6;
      4'd11:   t = 3'd2;
      4'd12:   t = 3'd4;
      default: t = 3'd4;
    endcase
    return t;
  endfunction

endpackage

// File: sv/cdts_wday.sv
// Weekday unit: builds the day sum, then reduces it modulo seven with one shared subtractor.
module cdts_wday (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [4:0]       day,
  input  logic [3:0]       month,
  input  logic [11:0]      year,
  output cdts_pkg::wd_stat_t stat
);
  import cdts_pkg::*;

  logic       busy_r, busy_nxt;
  logic       done_r, done_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic [2:0] k_r, k_nxt;

  logic [6:0] yy;
  logic [7:0] wsum;
  logic [7:0] sub;

  assign yy   = 7'(year - YEAR_MIN);
  assign wsum = 8'(8'(yy) + 8'(yy[6:2]) + 8'(day) + 8'(month_off(month))
                - 8'((year[1:0] == 2'b00) && (month < 4'd3)));
  assign sub  = 8'(8'd7 << k_r);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    k_nxt    = k_r;
    if (start) begin
      busy_nxt = 1'b1;
      rem_nxt  = (wsum == 8'd0) ? 8'd6 : 8'(wsum - 8'd1);
      k_nxt    = 3'd4;
    end else if (busy_r) begin
      if (rem_r >= sub) begin
        rem_nxt = 8'(rem_r - sub);
      end
      if (k_r == 3'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        k_nxt = 3'(k_r - 3'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    k_r   <= k_nxt;
  end

  assign stat.done = done_r;
  assign stat.wday = 3'(rem_r[2:0] + 3'd1);

endmodule

// File: sv/clock_date_time_setter.sv
// Top level of the clock date and time setter: request decode, field edit and result register.
// Load, time steps, save and cancel pass the edit and done states before the result is registered;
// date steps also pass the weekday start and wait states, the wait taking five subtractor reduce steps.
// One request at a time: the next request is taken once the last result is registered,
// also while the previous result still waits on out_tready.
// Synchronous active-low reset: 2018-01-01 00:00:00, Monday, both changed flags clear.
module clock_date_time_setter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // load_hours, load_minutes, load_seconds, load_day,
                                  // load_month, load_year, load_weekday, zero pad
  input  logic [6:0]  in_tuser,   // mode, field, load_failed
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // hours, minutes, seconds, day, month, year, weekday,
                                  // time_changed, date_changed, zero pad
  output logic [0:0]  out_tuser,  // write_clock
  output logic        out_tlast   // finished
);
  import cdts_pkg::*;

  state_t      state_r, state_nxt;
  logic [2:0]  mode_r, mode_nxt;
  logic [2:0]  field_r, field_nxt;
  logic        fail_r, fail_nxt;
  ld_t         ld_r, ld_nxt;

  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  minute_r, minute_nxt;
  logic [5:0]  second_r, second_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [11:0] year_r, year_nxt;
  logic [2:0]  wday_r, wday_nxt;
  logic        tdirty_r, tdirty_nxt;
  logic        ddirty_r, ddirty_nxt;
  logic        wr_r, wr_nxt;
  logic        fin_r, fin_nxt;

  logic        ovalid_r, ovalid_nxt;
  res_t        ores_r, ores_nxt;
  logic        owr_r, owr_nxt;
  logic        ofin_r, ofin_nxt;

  logic        up;
  logic [3:0]  mon_new;
  logic [11:0] yr_new;
  logic [4:0]  dlen_cur, dlen_mon, dlen_yr;
  logic [3:0]  ld_mon;
  logic [11:0] ld_yr;
  logic [4:0]  ld_dlen, ld_day;

  logic        wd_start;
  wd_stat_t    wd_stat;

  cdts_wday u_wday (
    .clk   (clk),
    .rst_n (rst_n),
    .start (wd_start),
    .day   (day_r),
    .month (month_r),
    .year  (year_r),
    .stat  (wd_stat)
  );

  assign up       = (mode_r == MODE_UP);
  assign mon_new  = up ? ((month_r >= 4'd12) ? 4'd1 : 4'(month_r + 4'd1))
                       : ((month_r <= 4'd1) ? 4'd12 : 4'(month_r - 4'd1));
  assign yr_new   = up ? ((year_r >= YEAR_MAX) ? YEAR_MIN : 12'(year_r + 12'd1))
                       : ((year_r <= YEAR_MIN) ? YEAR_MAX : 12'(year_r - 12'd1));
  assign dlen_cur = days_in(month_r, year_r[1:0] == 2'b00);
  assign dlen_mon = days_in(mon_new, year_r[1:0] == 2'b00);
  assign dlen_yr  = days_in(month_r, yr_new[1:0] == 2'b00);

  assign ld_mon   = (ld_r.month < 4'd1) ? 4'd1 : ((ld_r.month > 4'd12) ? 4'd12 : ld_r.month);
  assign ld_yr    = (ld_r.year < YEAR_MIN) ? YEAR_MIN
                  : ((ld_r.year > YEAR_MAX) ? YEAR_MAX : ld_r.year);
  assign ld_dlen  = days_in(ld_mon, ld_yr[1:0] == 2'b00);
  assign ld_day   = (ld_r.day < 5'd1) ? 5'd1 : ((ld_r.day > ld_dlen) ? ld_dlen : ld_r.day);

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    field_nxt  = field_r;
    fail_nxt   = fail_r;
    ld_nxt     = ld_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    day_nxt    = day_r;
    month_nxt  = month_r;
    year_nxt   = year_r;
    wday_nxt   = wday_r;
    tdirty_nxt = tdirty_r;
    ddirty_nxt = ddirty_r;
    wr_nxt     = wr_r;
    fin_nxt    = fin_r;
    ores_nxt   = ores_r;
    owr_nxt    = owr_r;
    ofin_nxt   = ofin_r;
    ovalid_nxt = ovalid_r && !out_tready;
    wd_start   = 1'b0;
    in_tready  = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          mode_nxt  = in_tuser[2:0];
          field_nxt = in_tuser[5:3];
          fail_nxt  = in_tuser[6];
          ld_nxt    = ld_t'(in_tdata[40:0]);
          state_nxt = S_EDIT;
        end
      end
      S_EDIT: begin
        wr_nxt    = 1'b0;
        fin_nxt   = 1'b0;
        state_nxt = S_DONE;
        case (mode_r)
          MODE_LOAD: begin
            if (fail_r) begin
              hour_nxt   = 5'd0;
              minute_nxt = 6'd0;
              second_nxt = 6'd0;
              day_nxt    = 5'd1;
              month_nxt  = 4'd1;
              year_nxt   = YEAR_DEF;
              wday_nxt   = 3'd1;
              tdirty_nxt = 1'b1;
              ddirty_nxt = 1'b1;
            end else begin
              hour_nxt   = (ld_r.hours > 5'd23) ? 5'd23 : ld_r.hours;
              minute_nxt = (ld_r.minutes > 6'd59) ? 6'd59 : ld_r.minutes;
              second_nxt = (ld_r.seconds > 6'd59) ? 6'd59 : ld_r.seconds;
              day_nxt    = ld_day;
              month_nxt  = ld_mon;
              year_nxt   = ld_yr;
              wday_nxt   = (ld_r.weekday == 3'd0) ? 3'd1 : ld_r.weekday;
              tdirty_nxt = 1'b0;
              ddirty_nxt = 1'b0;
            end
          end
          MODE_UP, MODE_DOWN: begin
            case (field_r)
              FIELD_HOURS: begin
                hour_nxt   = up ? ((hour_r >= 5'd23) ? 5'd0 : 5'(hour_r + 5'd1))
                                : ((hour_r == 5'd0) ? 5'd23 : 5'(hour_r - 5'd1));
                tdirty_nxt = 1'b1;
              end
              FIELD_MINUTES: begin
                minute_nxt = up ? ((minute_r >= 6'd59) ? 6'd0 : 6'(minute_r + 6'd1))
                                : ((minute_r == 6'd0) ? 6'd59 : 6'(minute_r - 6'd1));
                tdirty_nxt = 1'b1;
              end
              FIELD_SECONDS: begin
                second_nxt = up ? ((second_r >= 6'd59) ? 6'd0 : 6'(second_r + 6'd1))
                                : ((second_r == 6'd0) ? 6'd59 : 6'(second_r - 6'd1));
                tdirty_nxt = 1'b1;
              end
              FIELD_DAY: begin
                day_nxt    = up ? ((day_r >= dlen_cur) ? 5'd1 : 5'(day_r + 5'd1))
                                : ((day_r <= 5'd1) ? dlen_cur : 5'(day_r - 5'd1));
                ddirty_nxt = 1'b1;
                state_nxt  = S_WSTART;
              end
              FIELD_MONTH: begin
                month_nxt  = mon_new;
                day_nxt    = (day_r > dlen_mon) ? dlen_mon : day_r;
                ddirty_nxt = 1'b1;
                state_nxt  = S_WSTART;
              end
              FIELD_YEAR: begin
                year_nxt   = yr_new;
                day_nxt    = (day_r > dlen_yr) ? dlen_yr : day_r;
                ddirty_nxt = 1'b1;
                state_nxt  = S_WSTART;
              end
              default: begin
              end
            endcase
          end
          MODE_SAVE: begin
            wr_nxt  = tdirty_r || ddirty_r;
            fin_nxt = 1'b1;
          end
          MODE_CANCEL: begin
            fin_nxt = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_WSTART: begin
        wd_start  = 1'b1;
        state_nxt = S_WWAIT;
      end
      S_WWAIT: begin
        if (wd_stat.done) begin
          wday_nxt  = wd_stat.wday;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!ovalid_r || out_tready) begin
          ores_nxt.hours        = hour_r;
          ores_nxt.minutes      = minute_r;
          ores_nxt.seconds      = second_r;
          ores_nxt.day          = day_r;
          ores_nxt.month        = month_r;
          ores_nxt.year         = year_r;
          ores_nxt.weekday      = wday_r;
          ores_nxt.time_changed = tdirty_r;
          ores_nxt.date_changed = ddirty_r;
          owr_nxt               = wr_r;
          ofin_nxt              = fin_r;
          ovalid_nxt            = 1'b1;
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      hour_r   <= 5'd0;
      minute_r <= 6'd0;
      second_r <= 6'd0;
      day_r    <= 5'd1;
      month_r  <= 4'd1;
      year_r   <= YEAR_DEF;
      wday_r   <= 3'd1;
      tdirty_r <= 1'b0;
      ddirty_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      hour_r   <= hour_nxt;
      minute_r <= minute_nxt;
      second_r <= second_nxt;
      day_r    <= day_nxt;
      month_r  <= month_nxt;
      year_r   <= year_nxt;
      wday_r   <= wday_nxt;
      tdirty_r <= tdirty_nxt;
      ddirty_r <= ddirty_nxt;
    end
    mode_r  <= mode_nxt;
    field_r <= field_nxt;
    fail_r  <= fail_nxt;
    ld_r    <= ld_nxt;
    wr_r    <= wr_nxt;
    fin_r   <= fin_nxt;
    ores_r  <= ores_nxt;
    owr_r   <= owr_nxt;
    ofin_r  <= ofin_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {5'b0, ores_r};
  assign out_tuser  = owr_r;
  assign out_tlast  = ofin_r;

`include "assert_macros.svh"

  `ASSERT_NEXT(a_accept_edit, clk, rst_n, in_tvalid && in_tready, state_r == S_EDIT)
  `ASSERT_IMPL(a_wd_done_wait, clk, rst_n, wd_stat.done, state_r == S_WWAIT)
  `ASSERT_IMPL(a_write_finishes, clk, rst_n, out_tvalid && out_tuser[0], out_tlast)
  `ASSERT_IMPL(a_wday_nonzero, clk, rst_n, out_tvalid, out_tdata[40:38] != 3'd0)

endmodule

// File: tb/sv/clock_setter_checker.sv
// Checker for the clock date and time setter: predicts each result and compares it.
module clock_setter_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic [6:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic [0:0]  out_tuser,
  input  logic        out_tlast,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import cdts_pkg::*;

  typedef struct {
    res_t view;
    logic write_clock;
    logic finished;
  } clock_view_t;

  clock_view_t clock_views[$];
  clock_view_t want;
  res_t        got;
  int          results_seen;

  logic [4:0]  cur_hours;
  logic [5:0]  cur_minutes;
  logic [5:0]  cur_seconds;
  logic [4:0]  cur_day;
  logic [3:0]  cur_month;
  logic [11:0] cur_year;
  logic [2:0]  cur_wday;
  logic        time_dirty;
  logic        date_dirty;

  initial begin
    mismatches = 0;
    outstanding = 0;
    results_seen = 0;
  end

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic [11:0] y);
    logic [4:0] n;
    case (m)
      4'd2:                    n = (y % 4 == 0) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      default:                 n = 5'd31;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] calc_weekday(input logic [4:0] d, input logic [3:0] m,
                                              input logic [11:0] y);
    int yy;
    int t;
    int w;
    yy = y % 100;
    case (m)
      4'd1:    t = 6;
      4'd2:    t = 2;
      4'd3:    t = 2;
      4'd4:    t = 5;
      4'd5:    t = 0;
      4'd6:    t = 3;
      4'd7:    t = 5;
      4'd8:    t = 1;
      4'd9:    t = 4;
      4'd10:   t = 6;
      4'd11:   t = 2;
      default: t = 4;
    endcase
    w = yy + yy / 4 + d + t;
    if ((y % 4 == 0) && (m < 4'd3)) w = w - 1;
    if (w == 0) w = 7;
    return 3'((w - 1) % 7 + 1);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [11:0] actual,
                             input logic [11:0] wanted);
    if (actual !== wanted)
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                results_seen, name, actual, wanted));
  endtask

  task automatic predict_clock_view(input logic [2:0] mode, input logic [2:0] field,
                                    input ld_t ld, input logic failed);
    clock_view_t v;
    logic        up;
    logic [4:0]  n;
    v.write_clock = 1'b0;
    v.finished = 1'b0;
    up = (mode == MODE_UP);
    case (mode)
      MODE_LOAD: begin
        if (failed) begin
          cur_hours = 5'd0;
          cur_minutes = 6'd0;
          cur_seconds = 6'd0;
          cur_day = 5'd1;
          cur_month = 4'd1;
          cur_year = YEAR_DEF;
          cur_wday = 3'd1;
          time_dirty = 1'b1;
          date_dirty = 1'b1;
        end else begin
          cur_hours = (ld.hours > 5'd23) ? 5'd23 : ld.hours;
          cur_minutes = (ld.minutes > 6'd59) ? 6'd59 : ld.minutes;
          cur_seconds = (ld.seconds > 6'd59) ? 6'd59 : ld.seconds;
          cur_month = (ld.month < 4'd1) ? 4'd1 : (ld.month > 4'd12) ? 4'd12 : ld.month;
          cur_year = (ld.year < YEAR_MIN) ? YEAR_MIN : (ld.year > YEAR_MAX) ? YEAR_MAX : ld.year;
          cur_day = (ld.day < 5'd1) ? 5'd1 : ld.day;
          n = month_days(cur_month, cur_year);
          if (cur_day > n) cur_day = n;
          cur_wday = (ld.weekday == 3'd0) ? 3'd1 : ld.weekday;
          time_dirty = 1'b0;
          date_dirty = 1'b0;
        end
      end
      MODE_UP, MODE_DOWN: begin
        case (field)
          FIELD_HOURS: begin
            if (up) cur_hours = (cur_hours >= 5'd23) ? 5'd0 : cur_hours + 5'd1;
            else cur_hours = (cur_hours == 5'd0) ? 5'd23 : cur_hours - 5'd1;
            time_dirty = 1'b1;
          end
          FIELD_MINUTES: begin
            if (up) cur_minutes = (cur_minutes >= 6'd59) ? 6'd0 : cur_minutes + 6'd1;
            else cur_minutes = (cur_minutes == 6'd0) ? 6'd59 : cur_minutes - 6'd1;
            time_dirty = 1'b1;
          end
          FIELD_SECONDS: begin
            if (up) cur_seconds = (cur_seconds >= 6'd59) ? 6'd0 : cur_seconds + 6'd1;
            else cur_seconds = (cur_seconds == 6'd0) ? 6'd59 : cur_seconds - 6'd1;
            time_dirty = 1'b1;
          end
          FIELD_DAY, FIELD_MONTH, FIELD_YEAR: begin
            if (field == FIELD_DAY) begin
              n = month_days(cur_month, cur_year);
              if (up) cur_day = (cur_day >= n) ? 5'd1 : cur_day + 5'd1;
              else cur_day = (cur_day <= 5'd1) ? n : cur_day - 5'd1;
            end else begin
              if (field == FIELD_MONTH) begin
                if (up) cur_month = (cur_month >= 4'd12) ? 4'd1 : cur_month + 4'd1;
                else cur_month = (cur_month <= 4'd1) ? 4'd12 : cur_month - 4'd1;
              end else begin
                if (up) cur_year = (cur_year >= YEAR_MAX) ? YEAR_MIN : cur_year + 12'd1;
                else cur_year = (cur_year <= YEAR_MIN) ? YEAR_MAX : cur_year - 12'd1;
              end
              n = month_days(cur_month, cur_year);
              if (cur_day > n) cur_day = n;
            end
            date_dirty = 1'b1;
            cur_wday = calc_weekday(cur_day, cur_month, cur_year);
          end
          default: ;
        endcase
      end
      MODE_SAVE: begin
        v.write_clock = time_dirty | date_dirty;
        v.finished = 1'b1;
      end
      MODE_CANCEL: v.finished = 1'b1;
      default: ;
    endcase
    v.view.hours = cur_hours;
    v.view.minutes = cur_minutes;
    v.view.seconds = cur_seconds;
    v.view.day = cur_day;
    v.view.month = cur_month;
    v.view.year = cur_year;
    v.view.weekday = cur_wday;
    v.view.time_changed = time_dirty;
    v.view.date_changed = date_dirty;
    clock_views.push_back(v);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cur_hours = 5'd0;
      cur_minutes = 6'd0;
      cur_seconds = 6'd0;
      cur_day = 5'd1;
      cur_month = 4'd1;
      cur_year = YEAR_DEF;
      cur_wday = 3'd1;
      time_dirty = 1'b0;
      date_dirty = 1'b0;
      clock_views.delete();
      outstanding <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (clock_views.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
        end else begin
          want = clock_views.pop_front();
          got = res_t'(out_tdata[42:0]);
          check_field("hours", got.hours, want.view.hours);
          check_field("minutes", got.minutes, want.view.minutes);
          check_field("seconds", got.seconds, want.view.seconds);
          check_field("day", got.day, want.view.day);
          check_field("month", got.month, want.view.month);
          check_field("year", got.year, want.view.year);
          check_field("weekday", got.weekday, want.view.weekday);
          check_field("time_changed", got.time_changed, want.view.time_changed);
          check_field("date_changed", got.date_changed, want.view.date_changed);
          check_field("write_clock", out_tuser[0], want.write_clock);
          check_field("finished", out_tlast, want.finished);
        end
      end
      if (in_tvalid && in_tready)
        predict_clock_view(in_tuser[2:0], in_tuser[5:3], ld_t'(in_tdata[40:0]), in_tuser[6]);
      outstanding <= clock_views.size();
    end
  end

endmodule

// File: tb/sv/tb_top.sv
// Testbench top for the clock date and time setter: stimulus, idling and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cdts_pkg::*;

  localparam int ITEM_TARGET = 1550;
  localparam int CYCLE_LIMIT = 600000;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [6:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;

  int mismatches;
  int outstanding;
  int cycle_count = 0;
  int stall_left = 0;
  int n_loads = 0;
  int n_steps = 0;
  int n_saves = 0;
  int n_cancels = 0;
  int n_other = 0;
  int issued = 0;
  int sessions = 0;
  bit steady = 1'b0;

  clock_date_time_setter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  clock_setter_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles with %0d results pending", cycle_count, outstanding);
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // hold out_tready low for random stalls; no new stall starts in quiet windows
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ((cycle_count % 4096) < 600 || $urandom_range(0, 99) < 70) begin
      out_tready <= 1'b1;
    end else begin
      stall_left <= pick_gap();
      out_tready <= 1'b0;
    end
  end

  function automatic ld_t mk_load(input int h, input int mi, input int s, input int d,
                                  input int mo, input int y, input int w);
    ld_t ld;
    ld.hours = 5'(h);
    ld.minutes = 6'(mi);
    ld.seconds = 6'(s);
    ld.day = 5'(d);
    ld.month = 4'(mo);
    ld.year = 12'(y);
    ld.weekday = 3'(w);
    return ld;
  endfunction

  function automatic ld_t rand_load();
    ld_t ld;
    if ($urandom_range(0, 99) < 80)
      ld = mk_load($urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59),
                   $urandom_range(1, 31), $urandom_range(1, 12), $urandom_range(2000, 2099),
                   $urandom_range(1, 7));
    else
      ld = ld_t'(41'({$urandom(), $urandom()}));
    return ld;
  endfunction

  function automatic logic [2:0] rand_field();
    if ($urandom_range(0, 99) < 6) return 3'($urandom_range(6, 7));
    return 3'($urandom_range(0, 5));
  endfunction

  task automatic issue(input logic [2:0] mode, input logic [2:0] field, input ld_t ld,
                       input logic failed);
    int gap;
    in_tdata <= {7'd0, ld};
    in_tuser <= {failed, field, mode};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    case (mode)
      MODE_LOAD:            n_loads++;
      MODE_UP, MODE_DOWN:   n_steps++;
      MODE_SAVE:            n_saves++;
      MODE_CANCEL:          n_cancels++;
      default:              n_other++;
    endcase
    if (mode <= MODE_CANCEL) issued++;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off the sender until every pending result is back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    ld_t noise;
    noise = rand_load();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(MODE_SAVE, FIELD_HOURS, noise, 1'b0);
    issue(MODE_CANCEL, FIELD_YEAR, noise, 1'b1);
    issue(MODE_LOAD, FIELD_HOURS, noise, 1'b1);
    issue(MODE_SAVE, FIELD_HOURS, noise, 1'b0);
    issue(MODE_LOAD, FIELD_HOURS, mk_load(23, 59, 59, 31, 12, 2099, 7), 1'b0);
    for (int f = FIELD_HOURS; f <= FIELD_YEAR; f++)
      issue(MODE_UP, 3'(f), noise, 1'b0);
    issue(MODE_LOAD, FIELD_HOURS, mk_load(0, 0, 0, 1, 1, 2000, 0), 1'b0);
    for (int f = FIELD_HOURS; f <= FIELD_YEAR; f++)
      issue(MODE_DOWN, 3'(f), noise, 1'b0);
    issue(MODE_SAVE, FIELD_HOURS, noise, 1'b0);
    issue(MODE_LOAD, FIELD_HOURS, mk_load(31, 63, 63, 31, 15, 4095, 0), 1'b0);
    issue(MODE_LOAD, FIELD_HOURS, mk_load(0, 0, 0, 0, 0, 0, 7), 1'b0);
    issue(MODE_LOAD, FIELD_HOURS, mk_load(12, 30, 30, 31, 1, 2024, 3), 1'b0);
    issue(MODE_UP, FIELD_MONTH, noise, 1'b0);
    issue(MODE_UP, FIELD_YEAR, noise, 1'b0);
    issue(MODE_UP, FIELD_DAY, noise, 1'b0);
    issue(MODE_UP, 3'd6, noise, 1'b0);
    issue(MODE_DOWN, 3'd7, noise, 1'b0);
    issue(3'd5, FIELD_DAY, noise, 1'b1);
    drain_results();

    while (issued < ITEM_TARGET) begin
      sessions++;
      if ($urandom_range(0, 99) < 10) steady = ~steady;
      if ($urandom_range(0, 99) < 6) begin
        issue(3'($urandom_range(5, 7)), 3'($urandom_range(0, 7)), rand_load(),
              1'($urandom_range(0, 1)));
      end else begin
        issue(MODE_LOAD, rand_field(), rand_load(), $urandom_range(0, 99) < 15);
        repeat ($urandom_range(3, 12))
          issue($urandom_range(0, 1) ? MODE_UP : MODE_DOWN, rand_field(), rand_load(),
                1'($urandom_range(0, 1)));
        issue($urandom_range(0, 1) ? MODE_SAVE : MODE_CANCEL, rand_field(), rand_load(),
              1'($urandom_range(0, 1)));
      end
      if (sessions % 40 == 0) drain_results();
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Ran %0d loads, %0d field steps, %0d saves, %0d cancels, %0d unused modes",
             n_loads, n_steps, n_saves, n_cancels, n_other);
    $display("over %0d sessions in %0d cycles with random stalls on both channels",
             sessions, cycle_count);
    if (mismatches == 0 && outstanding == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
